>>> design/papc_pkg.sv
`default_nettype none
package papc_pkg;

	// one lane per BGRA channel
	localparam int LANES      = 4;
	localparam int LANE_BLUE  = 0;
	localparam int LANE_GREEN = 1;
	localparam int LANE_RED   = 2;
	localparam int LANE_ALPHA = 3;

	typedef logic [7:0] chan_t;
	typedef logic [15:0] prod_t;

	// rounding bias for the divide by 255
	localparam prod_t RND_BIAS = 16'd127;
	localparam chan_t CHAN_MAX = 8'd255;

	// pixel operation codes
	localparam logic MODE_BLIT = 1'b0;
	localparam logic MODE_FILL = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_KEY_ENABLE = 3'd0;
	localparam cfg_idx_t CFG_KEY_RED    = 3'd1;
	localparam cfg_idx_t CFG_KEY_GREEN  = 3'd2;
	localparam cfg_idx_t CFG_KEY_BLUE   = 3'd3;

	// per-lane operands: result = addend + round(mult_a * mult_b / 255)
	typedef struct packed {
		chan_t mult_a;
		chan_t mult_b;
		chan_t addend;
	} lane_op_t;

endpackage
`default_nettype wire

>>> design/papc_lane.sv
`default_nettype none
module papc_lane (
	input  wire                 clk,
	input  wire                 en,
	input  papc_pkg::lane_op_t  op,
	output papc_pkg::chan_t     result
);
	import papc_pkg::*;

	prod_t      prod_s1;
	chan_t      addend_s1;
	logic [16:0] div_sum;
	chan_t      quot;

	// stage 1: product plus rounding bias
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1   <= prod_t'(op.mult_a) * prod_t'(op.mult_b) + RND_BIAS;
			addend_s1 <= op.addend;
		end
	end

	// x / 255 == (x + (x >> 8) + 1) >> 8 for x below 65535
	always_comb begin
		div_sum = {1'b0, prod_s1} + {9'd0, prod_s1[15:8]} + 17'd1;
		quot    = div_sum[15:8];
	end

	// sum wraps to 8 bits
	assign result = addend_s1 + quot;

endmodule
`default_nettype wire

>>> design/premultiplied_alpha_pixel_compositor_unit.sv
`default_nettype none
// Premultiplied-alpha BGRA compositor. Takes one pixel per clock while in_stall
// is low and returns one result per pixel: four channel lanes each register an
// 8x8 product in the first stage, then divide by 255 with rounding and add the
// source term into the output register. Blit mode (mode 0) computes
// source-over, out = src + round(dst * (255 - a) / 255), wrapping to 8 bits;
// keyed colors and alpha 0 give write_enable 0 with all channels 0. Fill mode
// (mode 1) premultiplies the source color by its alpha and always writes.
// Key registers may be changed only while no transaction is in flight.
module premultiplied_alpha_pixel_compositor_unit (
	input  wire                        clk,
	input  wire                        arst_n,
	// configuration
	input  wire                        cfg_write,
	input  papc_pkg::cfg_idx_t         cfg_index,
	input  papc_pkg::chan_t            cfg_data,
	// pixel in
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire                        mode,
	input  papc_pkg::chan_t            src_blue,
	input  papc_pkg::chan_t            src_green,
	input  papc_pkg::chan_t            src_red,
	input  papc_pkg::chan_t            src_alpha,
	input  papc_pkg::chan_t            dst_blue,
	input  papc_pkg::chan_t            dst_green,
	input  papc_pkg::chan_t            dst_red,
	input  papc_pkg::chan_t            dst_alpha,
	// pixel out
	output logic                       out_valid,
	input  wire                        out_stall,
	output papc_pkg::chan_t            out_blue,
	output papc_pkg::chan_t            out_green,
	output papc_pkg::chan_t            out_red,
	output papc_pkg::chan_t            out_alpha,
	output logic                       write_enable
);
	import papc_pkg::*;

	logic     key_enable_q;
	chan_t    key_red_q, key_green_q, key_blue_q;

	chan_t    src [LANES];
	chan_t    dst [LANES];
	chan_t    inv_alpha;
	logic     keyed;
	logic     we_in;
	lane_op_t ops [LANES];
	chan_t    lane_res [LANES];

	logic     valid_s1, valid_s2;
	logic     we_s1, we_s2;
	chan_t    out_s2 [LANES];
	logic     adv_s1, adv_s2;

	// key registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_enable_q <= 1'b0;
			key_red_q    <= '0;
			key_green_q  <= '0;
			key_blue_q   <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_KEY_ENABLE: key_enable_q <= cfg_data[0];
				CFG_KEY_RED:    key_red_q    <= cfg_data;
				CFG_KEY_GREEN:  key_green_q  <= cfg_data;
				CFG_KEY_BLUE:   key_blue_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline flow control
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// channel gather
	assign src[LANE_BLUE]  = src_blue;
	assign src[LANE_GREEN] = src_green;
	assign src[LANE_RED]   = src_red;
	assign src[LANE_ALPHA] = src_alpha;
	assign dst[LANE_BLUE]  = dst_blue;
	assign dst[LANE_GREEN] = dst_green;
	assign dst[LANE_RED]   = dst_red;
	assign dst[LANE_ALPHA] = dst_alpha;

	// write decision; opaque source falls out of the blend since inv is 0
	assign inv_alpha = CHAN_MAX - src_alpha;
	assign keyed = key_enable_q && (src_blue == key_blue_q) &&
		(src_green == key_green_q) && (src_red == key_red_q);
	assign we_in = (mode == MODE_FILL) || (!keyed && (src_alpha != '0));

	// lane operand select
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (mode == MODE_FILL) begin
				ops[i].mult_a = (i == LANE_ALPHA) ? '0 : src[i];
				ops[i].mult_b = src_alpha;
				ops[i].addend = (i == LANE_ALPHA) ? src_alpha : '0;
			end else begin
				ops[i].mult_a = dst[i];
				ops[i].mult_b = inv_alpha;
				ops[i].addend = src[i];
			end
		end
	end

	// channel lanes
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		papc_lane u_lane (
			.clk    (clk),
			.en     (adv_s1),
			.op     (ops[g]),
			.result (lane_res[g])
		);
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			we_s1 <= we_in;
		end
	end

	// stage 2: merge lanes into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			we_s2    <= 1'b0;
			for (int i = 0; i < LANES; i++) begin
				out_s2[i] <= '0;
			end
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
			we_s2    <= we_s1;
			for (int i = 0; i < LANES; i++) begin
				out_s2[i] <= we_s1 ? lane_res[i] : '0;
			end
		end
	end

	assign out_valid    = valid_s2;
	assign write_enable = we_s2;
	assign out_blue     = out_s2[LANE_BLUE];
	assign out_green    = out_s2[LANE_GREEN];
	assign out_red      = out_s2[LANE_RED];
	assign out_alpha    = out_s2[LANE_ALPHA];

endmodule
`default_nettype wire

>>> design/papc_checker.sv
`default_nettype none
module papc_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_stall,
	input wire                 out_valid,
	input wire                 out_stall,
	input wire papc_pkg::chan_t out_blue,
	input wire papc_pkg::chan_t out_green,
	input wire papc_pkg::chan_t out_red,
	input wire papc_pkg::chan_t out_alpha,
	input wire                 write_enable
);
	import papc_pkg::*;

	// a skipped pixel carries all-zero channels
	a_zero_on_skip: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !write_enable) |->
		(out_blue == '0 && out_green == '0 && out_red == '0 && out_alpha == '0))
		else $error("skipped pixel has nonzero channels");

	// input backpressure only comes from a held output transaction
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without output backpressure");

	// a stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		(out_valid && $stable(out_blue) && $stable(out_green) && $stable(out_red) &&
		 $stable(out_alpha) && $stable(write_enable)))
		else $error("stalled output changed");

endmodule

bind premultiplied_alpha_pixel_compositor_unit papc_checker u_papc_checker (.*);
`default_nettype wire
